[rtl/core/sva_pkg.sv]
package sva_pkg;

	typedef enum logic [2:0] {
		CMD_ALLOC        = 3'd0,
		CMD_RELEASE      = 3'd1,
		CMD_KEY_ON       = 3'd2,
		CMD_SET_VLIMIT   = 3'd3,
		CMD_SET_CLIMIT   = 3'd4,
		CMD_CLEAR_ALL    = 3'd5
	} cmd_t;

	localparam logic [6:0] PRIO_RESET  = 7'd64;
	localparam logic [6:0] CLIMIT_RESET = 7'd127;
	localparam logic [3:0] NOTES_MAX   = 4'hf;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [3:0]  chan;
		logic [6:0]  priority_req;
		logic [31:0] note_id;
		logic        mono_mode;
		logic [2:0]  voice_index;
		logic [6:0]  limit_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0] voice;
		logic       voice_valid;
		logic [3:0] released_chan;
		logic       released_valid;
		logic       legato;
		logic [3:0] note_count;
	} out_item_t;

	typedef struct packed {
		logic remove;
		logic push;
		logic load;
	} list_op_t;

endpackage

[rtl/core/sva_list.sv]
// Ordered voice list: remove closes the gap, push appends if absent and not full.
module sva_list #(
	parameter int VOICES    = 8,
	parameter int VW        = 3,
	parameter int LW        = 4,
	parameter bit INIT_FULL = 1'b0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sva_pkg::list_op_t op,
	input  logic [VW-1:0]     op_v,
	input  logic [LW-1:0]     load_len,
	input  logic [VW-1:0]     rd_idx,
	output logic [VW-1:0]     rd_data,
	input  logic [VW-1:0]     q_v,
	output logic              q_hit,
	output logic [LW-1:0]     len
);

	logic [VW-1:0]     ent_q [VOICES];
	logic [LW-1:0]     len_q;
	logic [VOICES-1:0] match;
	logic [VOICES-1:0] qmatch;

	always_comb begin
		for (int j = 0; j < VOICES; j++) begin
			match[j]  = (ent_q[j] == op_v) && (LW'(j) < len_q);
			qmatch[j] = (ent_q[j] == q_v) && (LW'(j) < len_q);
		end
	end

	assign q_hit   = |qmatch;
	assign rd_data = ent_q[rd_idx];
	assign len     = len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) ent_q[i] <= VW'(i);
			len_q <= INIT_FULL ? LW'(VOICES) : '0;
		end else if (op.load) begin
			for (int i = 0; i < VOICES; i++) ent_q[i] <= VW'(i);
			len_q <= load_len;
		end else if (op.remove) begin
			if (|match) begin
				// shift down every entry at or after the match
				for (int i = 0; i < VOICES - 1; i++) begin
					if ((match & ({VOICES{1'b1}} >> (VOICES - 1 - i))) != '0)
						ent_q[i] <= ent_q[i+1];
				end
				len_q <= len_q - LW'(1);
			end
		end else if (op.push) begin
			if ((len_q < LW'(VOICES)) && !(|match)) begin
				ent_q[len_q[VW-1:0]] <= op_v;
				len_q <= len_q + LW'(1);
			end
		end
	end

endmodule

[rtl/core/synth_voice_allocator.sv]
// S_IDLE takes an item, S_DECODE decodes it; key_on, channel limit, clear and unused
// codes go on to S_DONE. Mono alloc goes to S_APPLY; poly alloc scans the playing,
// then the free list, one entry per cycle, to S_APPLY and, if found, S_COMMIT. Release
// walks the playing list to the match; set_voice_limit steps S_LIMIT per voice added or
// dropped. One item at a time: req_ready returns as the result is loaded, and S_DONE
// waits while rsp_ready stalls. Reset (arst_n low) sets control, voice and channel state.
module synth_voice_allocator #(
	parameter int VOICES   = 8,
	parameter int CHANNELS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  sva_pkg::in_item_t  req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output sva_pkg::out_item_t rsp
);

	localparam int VW = $clog2(VOICES);
	localparam int LW = $clog2(VOICES + 1);
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Remainder by repeated subtraction; evaluated at elaboration only.
	function automatic int modc(input int x, input int m);
		int r;
		r = x;
		for (int k = 0; k < 16; k++) if (r >= m) r = r - m;
		return r;
	endfunction

	function automatic logic [16*CW-1:0] ch_table();
		logic [16*CW-1:0] t;
		t = '0;
		for (int x = 0; x < 16; x++) t[x*CW +: CW] = CW'(modc(x, CHANNELS));
		return t;
	endfunction

	function automatic logic [8*VW-1:0] fv_table();
		logic [8*VW-1:0] t;
		t = '0;
		for (int x = 0; x < 8; x++) t[x*VW +: VW] = VW'(modc(x, VOICES));
		return t;
	endfunction

	localparam logic [16*CW-1:0] CH_TAB = ch_table();
	localparam logic [8*VW-1:0]  FV_TAB = fv_table();

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_APPLY  = 7'b0001000,
		S_COMMIT = 7'b0010000,
		S_LIMIT  = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t state_q;

	// captured item
	logic [2:0]    cmd_q;
	logic [CW-1:0] ci_q;
	logic [6:0]    prio_q;
	logic [31:0]   nid_q;
	logic          mono_q;
	logic [2:0]    vidx_q;
	logic [6:0]    lim_q;

	// sequencer working registers
	logic [VW-1:0] idx_q;
	logic [VW-1:0] v_q;
	logic [6:0]    best_q;
	logic          found_q, from_play_q, over_q, scan_free_q;
	logic          legato_q, vvalid_q, rvalid_q;
	logic [CW-1:0] rch_q;
	logic [LW-1:0] i_q, nl_q, end_q, limit_q;
	logic          shrink_q;

	// voice and channel state
	logic [CW-1:0]     vchan_q [VOICES];
	logic [6:0]        vprio_q [VOICES];
	logic [31:0]       vnid_q  [VOICES];
	logic [VOICES-1:0] vkey_q;
	logic [3:0]        notes_q [CHANNELS];
	logic [6:0]        climit_q [CHANNELS];

	// output register
	sva_pkg::out_item_t out_q;
	logic               outv_q;

	// list control
	sva_pkg::list_op_t play_op, free_op;
	logic [VW-1:0]     play_v, free_v, play_qv, free_qv, play_rd, free_rd;
	logic [LW-1:0]     free_load_len, play_len, free_len;
	logic              play_hit, free_hit;

	// shared scan path
	logic [VW-1:0] sv, attr_a;
	logic [CW-1:0] a_chan;
	logic [6:0]    a_prio;
	logic [31:0]   a_nid;
	logic          a_key;
	logic          cand;
	logic [VW-1:0] iv;

	// note count write port
	logic          notes_we, notes_inc;
	logic [CW-1:0] notes_a;
	logic [3:0]    notes_cur, notes_new;

	sva_list #(.VOICES(VOICES), .VW(VW), .LW(LW), .INIT_FULL(1'b0)) u_play (
		.clk(clk), .arst_n(arst_n), .op(play_op), .op_v(play_v),
		.load_len(LW'(0)), .rd_idx(idx_q), .rd_data(play_rd),
		.q_v(play_qv), .q_hit(play_hit), .len(play_len)
	);

	sva_list #(.VOICES(VOICES), .VW(VW), .LW(LW), .INIT_FULL(1'b1)) u_free (
		.clk(clk), .arst_n(arst_n), .op(free_op), .op_v(free_v),
		.load_len(free_load_len), .rd_idx(idx_q), .rd_data(free_rd),
		.q_v(free_qv), .q_hit(free_hit), .len(free_len)
	);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = outv_q;
	assign rsp       = out_q;

	// Attribute reads use one address: the scanned entry, else the chosen voice.
	assign sv     = scan_free_q ? free_rd : play_rd;
	assign attr_a = (state_q == S_SCAN) ? sv : v_q;
	assign a_chan = vchan_q[attr_a];
	assign a_prio = vprio_q[attr_a];
	assign a_nid  = vnid_q[attr_a];
	assign a_key  = vkey_q[attr_a];
	assign iv     = i_q[VW-1:0];

	// Candidate test: lowest priority, later (older) entries win ties on <=;
	// over-limit only looks at the item's own channel.
	assign cand = (!found_q || (a_prio <= best_q)) && (!over_q || (a_chan == ci_q));

	assign notes_cur = notes_q[notes_a];
	assign notes_new = notes_inc ? ((notes_cur == sva_pkg::NOTES_MAX) ? notes_cur
		: notes_cur + 4'd1) : ((notes_cur == 4'd0) ? notes_cur : notes_cur - 4'd1);

	always_comb begin
		play_op       = '0;
		free_op       = '0;
		play_v        = v_q;
		free_v        = v_q;
		play_qv       = v_q;
		free_qv       = v_q;
		free_load_len = limit_q;
		notes_we      = 1'b0;
		notes_inc     = 1'b0;
		notes_a       = ci_q;
		unique case (state_q)
			S_DECODE: begin
				if (cmd_q == sva_pkg::CMD_CLEAR_ALL) begin
					play_op.load = 1'b1;
					free_op.load = 1'b1;
				end
			end
			S_APPLY: begin
				if (cmd_q == sva_pkg::CMD_ALLOC) begin
					if (mono_q) begin
						if (play_hit) begin
							if (a_chan == ci_q) begin
								if (!a_key) begin
									// retrigger: drop from playing, count kept net
									play_op.remove = 1'b1;
									notes_we       = 1'b1;
								end
							end else begin
								play_op.remove = 1'b1;
								notes_we       = 1'b1;
								notes_a        = a_chan;
							end
						end else begin
							free_op.remove = 1'b1;
						end
					end else if (found_q) begin
						if (from_play_q) begin
							play_op.remove = 1'b1;
							notes_we       = 1'b1;
							notes_a        = a_chan;
						end else begin
							free_op.remove = 1'b1;
						end
					end
				end else begin
					play_op.remove = 1'b1;
					free_op.push   = (LW'(v_q) < limit_q);
					notes_we       = 1'b1;
				end
			end
			S_COMMIT: begin
				if (!legato_q) begin
					play_op.push = 1'b1;
					notes_we     = 1'b1;
					notes_inc    = 1'b1;
				end
			end
			S_LIMIT: begin
				play_qv = iv;
				free_qv = iv;
				free_v  = iv;
				if (i_q < end_q) begin
					if (shrink_q) free_op.remove = 1'b1;
					else free_op.push = !play_hit && !free_hit;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			outv_q  <= 1'b0;
			limit_q <= LW'(VOICES);
			vkey_q  <= '0;
			for (int i = 0; i < VOICES; i++) begin
				vchan_q[i] <= '0;
				vprio_q[i] <= sva_pkg::PRIO_RESET;
				vnid_q[i]  <= '0;
			end
			for (int c = 0; c < CHANNELS; c++) begin
				notes_q[c]  <= '0;
				climit_q[c] <= sva_pkg::CLIMIT_RESET;
			end
		end else begin
			if (outv_q && rsp_ready) outv_q <= 1'b0;
			if (notes_we) notes_q[notes_a] <= notes_new;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmd_q   <= req.cmd;
						ci_q    <= CH_TAB[req.chan*CW +: CW];
						prio_q  <= req.priority_req;
						nid_q   <= req.note_id;
						mono_q  <= req.mono_mode;
						vidx_q  <= req.voice_index;
						lim_q   <= req.limit_value;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					found_q     <= 1'b0;
					from_play_q <= 1'b0;
					legato_q    <= 1'b0;
					vvalid_q    <= 1'b0;
					rvalid_q    <= 1'b0;
					scan_free_q <= 1'b0;
					over_q      <= 1'b0;
					state_q     <= S_DONE;
					unique case (cmd_q)
						sva_pkg::CMD_ALLOC: begin
							if (mono_q) begin
								// fixed voice from the low three channel bits
								v_q     <= FV_TAB[3'(ci_q)*VW +: VW];
								state_q <= S_APPLY;
							end else begin
								over_q <= ({3'b000, notes_q[ci_q]} >= climit_q[ci_q]);
								if (play_len != '0) begin
									idx_q   <= VW'(play_len - LW'(1));
									state_q <= S_SCAN;
								end else if (({3'b000, notes_q[ci_q]} < climit_q[ci_q])
									&& (free_len != '0)) begin
									scan_free_q <= 1'b1;
									idx_q       <= VW'(free_len - LW'(1));
									state_q     <= S_SCAN;
								end else begin
									state_q <= S_APPLY;
								end
							end
						end
						sva_pkg::CMD_RELEASE: begin
							if (play_len != '0) begin
								idx_q   <= '0;
								state_q <= S_SCAN;
							end
						end
						sva_pkg::CMD_KEY_ON: begin
							if (32'(vidx_q) < VOICES) vkey_q[VW'(vidx_q)] <= 1'b1;
						end
						sva_pkg::CMD_SET_VLIMIT: begin
							if (lim_q > 7'(VOICES)) begin
								nl_q     <= LW'(VOICES);
								shrink_q <= (LW'(VOICES) < limit_q);
								i_q      <= (LW'(VOICES) < limit_q) ? LW'(VOICES) : limit_q;
								end_q    <= (LW'(VOICES) < limit_q) ? limit_q : LW'(VOICES);
							end else begin
								nl_q     <= LW'(lim_q);
								shrink_q <= (LW'(lim_q) < limit_q);
								i_q      <= (LW'(lim_q) < limit_q) ? LW'(lim_q) : limit_q;
								end_q    <= (LW'(lim_q) < limit_q) ? limit_q : LW'(lim_q);
							end
							state_q <= S_LIMIT;
						end
						sva_pkg::CMD_SET_CLIMIT: begin
							climit_q[ci_q] <= lim_q;
						end
						sva_pkg::CMD_CLEAR_ALL: begin
							// keep the voice limit; lists reload in the list units
							vkey_q <= '0;
							for (int i = 0; i < VOICES; i++) begin
								vchan_q[i] <= '0;
								vprio_q[i] <= sva_pkg::PRIO_RESET;
								vnid_q[i]  <= '0;
							end
							for (int c = 0; c < CHANNELS; c++) begin
								notes_q[c]  <= '0;
								climit_q[c] <= sva_pkg::CLIMIT_RESET;
							end
						end
						default: ;
					endcase
				end
				S_SCAN: begin
					if (cmd_q == sva_pkg::CMD_RELEASE) begin
						// walk oldest first, stop at the first id match
						if (a_nid == nid_q) begin
							v_q     <= sv;
							found_q <= 1'b1;
							state_q <= S_APPLY;
						end else if (LW'(idx_q) == play_len - LW'(1)) begin
							state_q <= S_DONE;
						end else begin
							idx_q <= idx_q + VW'(1);
						end
					end else begin
						if (cand) begin
							best_q      <= a_prio;
							v_q         <= sv;
							found_q     <= 1'b1;
							from_play_q <= !scan_free_q;
						end
						if (idx_q == '0) begin
							if (!scan_free_q && !over_q && (free_len != '0)) begin
								scan_free_q <= 1'b1;
								idx_q       <= VW'(free_len - LW'(1));
							end else begin
								state_q <= S_APPLY;
							end
						end else begin
							idx_q <= idx_q - VW'(1);
						end
					end
				end
				S_APPLY: begin
					if (cmd_q == sva_pkg::CMD_ALLOC) begin
						state_q <= S_COMMIT;
						if (mono_q) begin
							if (play_hit && (a_chan == ci_q) && a_key) legato_q <= 1'b1;
							if (play_hit && (a_chan != ci_q)) begin
								rch_q    <= a_chan;
								rvalid_q <= 1'b1;
							end
						end else if (!found_q) begin
							state_q <= S_DONE;
						end else if (from_play_q) begin
							rch_q    <= a_chan;
							rvalid_q <= 1'b1;
						end
					end else begin
						if (a_key) begin
							vnid_q[v_q]  <= '0;
							vprio_q[v_q] <= prio_q;
							vkey_q[v_q]  <= 1'b0;
						end
						vvalid_q <= 1'b1;
						state_q  <= S_DONE;
					end
				end
				S_COMMIT: begin
					vchan_q[v_q] <= ci_q;
					vprio_q[v_q] <= prio_q;
					vnid_q[v_q]  <= nid_q;
					vkey_q[v_q]  <= 1'b0;
					vvalid_q     <= 1'b1;
					state_q      <= S_DONE;
				end
				S_LIMIT: begin
					if (i_q < end_q) begin
						if (!shrink_q && !play_hit && !free_hit) begin
							vchan_q[iv] <= '0;
							vprio_q[iv] <= '0;
						end
						i_q <= i_q + LW'(1);
					end else begin
						limit_q <= nl_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold the result until the output register is free
					if (!outv_q || rsp_ready) begin
						out_q.voice          <= vvalid_q ? 3'(v_q) : 3'd0;
						out_q.voice_valid    <= vvalid_q;
						out_q.released_chan  <= rvalid_q ? 4'(rch_q) : 4'd0;
						out_q.released_valid <= rvalid_q;
						out_q.legato         <= legato_q;
						out_q.note_count     <= notes_q[ci_q];
						outv_q               <= 1'b1;
						state_q              <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/sva_checker.sv]
module sva_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input sva_pkg::in_item_t  req,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input sva_pkg::out_item_t rsp
);

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("input item changed while waiting");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("accepted an item while busy");

	a_steal_has_voice: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.released_valid |-> rsp.voice_valid && !rsp.legato)
		else $error("steal reported without a voice or with legato");

	a_no_voice_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.voice_valid |-> (rsp.voice == 3'd0) && !rsp.legato
		&& (rsp.released_chan == 4'd0))
		else $error("empty result carries voice fields");

endmodule

bind synth_voice_allocator sva_checker u_sva_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
	.req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
